// ===== rtl/assert_macros.svh =====
// assertion helpers, sampled on the rising edge of clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define KHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define KHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/kht_pkg.sv =====
`default_nettype none

package kht_pkg;

  localparam int SLOTS      = 4;
  localparam int SCAN_SPACE = 128;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CODE_W     = 7;
  localparam int CHAR_W     = 7;
  localparam int AGE_W      = 8;
  localparam int TMO_W      = 8;

  localparam logic [AGE_W-1:0] AGE_MAX   = 8'hFF;
  localparam logic [7:0]       CHAR_LO   = 8'd32;
  localparam logic [7:0]       CHAR_HI   = 8'd126;
  localparam logic [TMO_W-1:0] TMO_RESET = 8'd4;

  localparam logic CMD_MAKE     = 1'b0;
  localparam logic CMD_TICK     = 1'b1;
  localparam logic KIND_PRESS   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] scan_code;
    logic [7:0] key_char;
    logic       key_ignored;
  } kht_in_t;

  typedef struct packed {
    logic              event_kind;
    logic [CODE_W-1:0] key_code;
    logic              text_valid;
    logic [CHAR_W-1:0] text_char;
    logic              last_of_run;
  } kht_out_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_VISIT = 5'b00100,
    ST_MOVE  = 5'b01000,
    ST_FLUSH = 5'b10000
  } kht_state_t;

endpackage

`default_nettype wire

// ===== rtl/key_hold_timeout_tracker.sv =====
// make code: skipped codes leave the block idle, else one slot compared per cycle
// tick: one slot aged per cycle unless a release waits on the output; removed slots refilled from the last slot
// one item at a time; in_ready is low while an item is being worked, also during output stalls
// reset (rst_n low, synchronous): no held keys, release_timeout back to 4, output empty
// no clearing pass; pressed state is derived from the slot list
`default_nettype none
`include "assert_macros.svh"

module key_hold_timeout_tracker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire kht_pkg::kht_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output kht_pkg::kht_out_t               out_data,
  input  wire logic                       cfg_we,
  input  wire logic [kht_pkg::TMO_W-1:0]  cfg_wdata
);

  kht_pkg::kht_state_t state_r, state_nxt;

  logic [kht_pkg::TMO_W-1:0]  tmo_r;
  logic [kht_pkg::CNT_W-1:0]  slot_cnt_r, slot_cnt_nxt;
  logic [kht_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [kht_pkg::CODE_W-1:0] key_r, key_nxt;
  logic [7:0]                 ch_r, ch_nxt;
  logic                       pend_vld_r, pend_vld_nxt;
  logic [kht_pkg::CODE_W-1:0] pend_key_r, pend_key_nxt;
  logic                       out_valid_r, out_valid_nxt;
  kht_pkg::kht_out_t          out_data_r, out_data_nxt;

  logic [kht_pkg::CODE_W-1:0] slot_key_r [kht_pkg::SLOTS];
  logic [kht_pkg::AGE_W-1:0]  slot_age_r [kht_pkg::SLOTS];

  logic [kht_pkg::IDX_W-1:0]  rd_idx;
  logic [kht_pkg::CODE_W-1:0] rd_key;
  logic [kht_pkg::AGE_W-1:0]  rd_age;
  logic [kht_pkg::AGE_W-1:0]  age_inc;

  logic                       key_we;
  logic [kht_pkg::IDX_W-1:0]  key_widx;
  logic [kht_pkg::CODE_W-1:0] key_wdata;
  logic                       age_we;
  logic [kht_pkg::IDX_W-1:0]  age_widx;
  logic [kht_pkg::AGE_W-1:0]  age_wdata;
  logic                       age_clr;

  logic in_fire;
  logic out_free;
  logic key_ok;
  logic printable;
  logic at_end;

  assign in_ready  = (state_r == kht_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign key_ok = !in_data.key_ignored && (in_data.scan_code != 8'd0) &&
                  ({1'b0, in_data.scan_code} < 9'(kht_pkg::SCAN_SPACE));
  assign printable = (ch_r >= kht_pkg::CHAR_LO) && (ch_r <= kht_pkg::CHAR_HI);
  assign at_end    = (idx_r == slot_cnt_r);

  // single read port over the slot list; refill reads the last slot
  assign rd_idx  = (state_r == kht_pkg::ST_MOVE) ? slot_cnt_r[kht_pkg::IDX_W-1:0]
                                                 : idx_r[kht_pkg::IDX_W-1:0];
  assign rd_key  = slot_key_r[rd_idx];
  assign rd_age  = slot_age_r[rd_idx];
  assign age_inc = (rd_age == kht_pkg::AGE_MAX) ? rd_age : rd_age + 8'd1;

  always_comb begin
    state_nxt     = state_r;
    slot_cnt_nxt  = slot_cnt_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    ch_nxt        = ch_r;
    pend_vld_nxt  = pend_vld_r;
    pend_key_nxt  = pend_key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    key_we        = 1'b0;
    key_widx      = idx_r[kht_pkg::IDX_W-1:0];
    key_wdata     = rd_key;
    age_we        = 1'b0;
    age_widx      = idx_r[kht_pkg::IDX_W-1:0];
    age_wdata     = rd_age;
    age_clr       = 1'b0;

    case (state_r)
      kht_pkg::ST_IDLE: begin
        if (in_fire) begin
          idx_nxt = '0;
          key_nxt = in_data.scan_code[kht_pkg::CODE_W-1:0];
          ch_nxt  = in_data.key_char;
          if (in_data.command == kht_pkg::CMD_TICK) begin
            state_nxt = kht_pkg::ST_VISIT;
          end else if (key_ok) begin
            state_nxt = kht_pkg::ST_SCAN;
          end
        end
      end

      kht_pkg::ST_SCAN: begin
        if (!at_end) begin
          if (rd_key == key_r) begin
            // key already held: autorepeat just refreshes the ages
            age_clr   = 1'b1;
            state_nxt = kht_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (slot_cnt_r == kht_pkg::CNT_W'(kht_pkg::SLOTS)) begin
          state_nxt = kht_pkg::ST_IDLE;
        end else if (out_free) begin
          key_we        = 1'b1;
          key_widx      = slot_cnt_r[kht_pkg::IDX_W-1:0];
          key_wdata     = key_r;
          age_clr       = 1'b1;
          slot_cnt_nxt  = slot_cnt_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt.event_kind  = kht_pkg::KIND_PRESS;
          out_data_nxt.key_code    = key_r;
          out_data_nxt.text_valid  = printable;
          out_data_nxt.text_char   = printable ? ch_r[kht_pkg::CHAR_W-1:0] : '0;
          out_data_nxt.last_of_run = 1'b1;
          state_nxt     = kht_pkg::ST_IDLE;
        end
      end

      kht_pkg::ST_VISIT: begin
        if (at_end) begin
          state_nxt = kht_pkg::ST_FLUSH;
        end else if (age_inc > tmo_r) begin
          // a release held back until we know whether another one follows
          if (!pend_vld_r || out_free) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt.event_kind  = kht_pkg::KIND_RELEASE;
              out_data_nxt.key_code    = pend_key_r;
              out_data_nxt.text_valid  = 1'b0;
              out_data_nxt.text_char   = '0;
              out_data_nxt.last_of_run = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_key_nxt = rd_key;
            slot_cnt_nxt = slot_cnt_r - 1'b1;
            if (idx_r < slot_cnt_nxt) begin
              state_nxt = kht_pkg::ST_MOVE;
            end
          end
        end else begin
          age_we    = 1'b1;
          age_wdata = age_inc;
          idx_nxt   = idx_r + 1'b1;
        end
      end

      kht_pkg::ST_MOVE: begin
        // last slot fills the hole, then the same position is visited again
        key_we    = 1'b1;
        key_wdata = rd_key;
        age_we    = 1'b1;
        age_wdata = rd_age;
        state_nxt = kht_pkg::ST_VISIT;
      end

      kht_pkg::ST_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = kht_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.event_kind  = kht_pkg::KIND_RELEASE;
          out_data_nxt.key_code    = pend_key_r;
          out_data_nxt.text_valid  = 1'b0;
          out_data_nxt.text_char   = '0;
          out_data_nxt.last_of_run = 1'b1;
          pend_vld_nxt  = 1'b0;
          state_nxt     = kht_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = kht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kht_pkg::ST_IDLE;
      tmo_r       <= kht_pkg::TMO_RESET;
      slot_cnt_r  <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_cnt_r  <= slot_cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tmo_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    ch_r       <= ch_nxt;
    pend_key_r <= pend_key_nxt;
    out_data_r <= out_data_nxt;
    if (key_we) begin
      slot_key_r[key_widx] <= key_wdata;
    end
    for (int i = 0; i < kht_pkg::SLOTS; i++) begin
      if (age_clr) begin
        slot_age_r[i] <= '0;
      end else if (age_we && (age_widx == kht_pkg::IDX_W'(i))) begin
        slot_age_r[i] <= age_wdata;
      end
    end
  end

  `KHT_ASSERT(a_cnt_bound, slot_cnt_r <= kht_pkg::CNT_W'(kht_pkg::SLOTS), "slot count overflow")
  `KHT_ASSERT(a_pend_in_tick, pend_vld_r |-> !in_ready, "held release outside tick walk")
  `KHT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "beat lost")
  `KHT_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> (slot_cnt_r == '0 && !out_valid_r), "reset left state")

endmodule

`default_nettype wire

// ===== bench/key_hold_timeout_tracker_test.sv =====
module key_hold_timeout_tracker_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  kht_pkg::kht_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  kht_pkg::kht_out_t out_data;
  logic cfg_we = 1'b0;
  logic [kht_pkg::TMO_W-1:0] cfg_wdata = '0;

  key_hold_timeout_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // model of the held-key list
  logic [kht_pkg::TMO_W-1:0] hold_limit;
  logic held_map [kht_pkg::SCAN_SPACE];
  logic [kht_pkg::CODE_W-1:0] held_key [kht_pkg::SLOTS];
  logic [kht_pkg::AGE_W-1:0] held_age [kht_pkg::SLOTS];
  int held_count;

  kht_pkg::kht_in_t pending_items [$];
  kht_pkg::kht_out_t expected_events [$];
  kht_pkg::kht_out_t oldest_event;

  int send_gap = 0;
  int send_calm = 0;
  int stall_left = 0;
  int stall_calm = 0;
  int mismatches = 0;
  int items_accepted = 0;
  int presses_seen = 0;
  int releases_seen = 0;
  int cycle_count = 0;
  logic [7:0] key_pool [6];

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic clear_held_keys();
    hold_limit = kht_pkg::TMO_RESET;
    held_count = 0;
    for (int k = 0; k < kht_pkg::SCAN_SPACE; k++) held_map[k] = 1'b0;
    for (int s = 0; s < kht_pkg::SLOTS; s++) begin
      held_key[s] = '0;
      held_age[s] = '0;
    end
  endtask

  // works out the press/release beats one input item causes
  task automatic track_item(input kht_pkg::kht_in_t item);
    kht_pkg::kht_out_t ev;
    kht_pkg::kht_out_t run [$];
    logic [kht_pkg::CODE_W-1:0] code;
    logic printable;
    int i;
    if (item.command == kht_pkg::CMD_MAKE) begin
      if (item.key_ignored || item.scan_code == 8'd0 ||
          item.scan_code >= kht_pkg::SCAN_SPACE) return;
      code = item.scan_code[kht_pkg::CODE_W-1:0];
      if (!held_map[code]) begin
        // new key with no free slot: dropped, ages untouched
        if (held_count >= kht_pkg::SLOTS) return;
        held_key[held_count] = code;
        held_age[held_count] = '0;
        held_count++;
        held_map[code] = 1'b1;
        printable = (item.key_char >= kht_pkg::CHAR_LO) &&
                    (item.key_char <= kht_pkg::CHAR_HI);
        ev.event_kind = kht_pkg::KIND_PRESS;
        ev.key_code = code;
        ev.text_valid = printable;
        ev.text_char = printable ? item.key_char[kht_pkg::CHAR_W-1:0] : '0;
        ev.last_of_run = 1'b1;
        expected_events.push_back(ev);
      end
      for (int s = 0; s < kht_pkg::SLOTS; s++) held_age[s] = '0;
    end else begin
      i = 0;
      while (i < held_count) begin
        if (held_age[i] != kht_pkg::AGE_MAX) held_age[i] = held_age[i] + 1'b1;
        if (held_age[i] > hold_limit) begin
          ev.event_kind = kht_pkg::KIND_RELEASE;
          ev.key_code = held_key[i];
          ev.text_valid = 1'b0;
          ev.text_char = '0;
          ev.last_of_run = 1'b0;
          run.push_back(ev);
          held_map[held_key[i]] = 1'b0;
          held_count--;
          // last slot fills the hole, same index checked again
          if (i < held_count) begin
            held_key[i] = held_key[held_count];
            held_age[i] = held_age[held_count];
          end
        end else begin
          i++;
        end
      end
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[k]) expected_events.push_back(run[k]);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic kht_pkg::kht_in_t key_beat(input logic [7:0] scan, input logic [7:0] ch,
                                                input logic ign);
    kht_pkg::kht_in_t b;
    b.command = kht_pkg::CMD_MAKE;
    b.scan_code = scan;
    b.key_char = ch;
    b.key_ignored = ign;
    return b;
  endfunction

  // tick fields other than command carry junk
  function automatic kht_pkg::kht_in_t tick_beat();
    kht_pkg::kht_in_t b;
    b.command = kht_pkg::CMD_TICK;
    b.scan_code = 8'($urandom_range(0, 255));
    b.key_char = 8'($urandom_range(0, 255));
    b.key_ignored = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic kht_pkg::kht_in_t random_beat();
    int r;
    logic [7:0] ch;
    r = $urandom_range(0, 99);
    ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(32, 126));
    if (r < 4) return key_beat(8'($urandom_range(1, 127)), ch, 1'b1);
    if (r < 7) return key_beat(8'd0, ch, 1'($urandom_range(0, 1)));
    if (r < 11) return key_beat(8'($urandom_range(128, 255)), ch, 1'($urandom_range(0, 1)));
    if (r < 42) return tick_beat();
    if (r < 80) return key_beat(key_pool[$urandom_range(0, 5)], ch, 1'b0);
    return key_beat(8'($urandom_range(1, 127)), ch, 1'b0);
  endfunction

  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [kht_pkg::TMO_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    hold_limit = value;
  endtask

  // random beats, then enough ticks to empty the held list
  task automatic queue_random(input int count);
    @(negedge clk);
    repeat (count) pending_items.push_back(random_beat());
    repeat (int'(hold_limit) + 2) pending_items.push_back(tick_beat());
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_item(in_data);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = pick_gap();
            if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(10, 30);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (stall_calm > 0) begin
        stall_calm--;
      end else begin
        stall_left = pick_gap();
        if ($urandom_range(0, 19) == 0) stall_calm = $urandom_range(10, 30);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d code=%0d",
                                  out_data.event_kind, out_data.key_code));
      end else begin
        oldest_event = expected_events.pop_front();
        if (out_data.event_kind !== oldest_event.event_kind)
          report_mismatch($sformatf("event_kind %0d, want %0d",
                                    out_data.event_kind, oldest_event.event_kind));
        if (out_data.key_code !== oldest_event.key_code)
          report_mismatch($sformatf("key_code %0d, want %0d",
                                    out_data.key_code, oldest_event.key_code));
        if (out_data.text_valid !== oldest_event.text_valid)
          report_mismatch($sformatf("text_valid %0d, want %0d",
                                    out_data.text_valid, oldest_event.text_valid));
        if (out_data.text_char !== oldest_event.text_char)
          report_mismatch($sformatf("text_char %0d, want %0d",
                                    out_data.text_char, oldest_event.text_char));
        if (out_data.last_of_run !== oldest_event.last_of_run)
          report_mismatch($sformatf("last_of_run %0d, want %0d",
                                    out_data.last_of_run, oldest_event.last_of_run));
        if (oldest_event.event_kind == kht_pkg::KIND_PRESS) presses_seen++;
        else releases_seen++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  initial begin
    clear_held_keys();
    for (int k = 0; k < 6; k++) key_pool[k] = 8'($urandom_range(1, 127));
    key_pool[5] = 8'd127;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, ignored codes, repeats, full list, release of all
    @(negedge clk);
    pending_items.push_back(key_beat(8'd1, 8'd65, 1'b0));
    pending_items.push_back(key_beat(8'd127, 8'd0, 1'b0));
    pending_items.push_back(key_beat(8'd0, 8'd66, 1'b0));
    pending_items.push_back(key_beat(8'd128, 8'd67, 1'b0));
    pending_items.push_back(key_beat(8'd255, 8'd255, 1'b0));
    pending_items.push_back(key_beat(8'd5, 8'd70, 1'b1));
    pending_items.push_back(key_beat(8'd1, 8'd65, 1'b0));
    pending_items.push_back(key_beat(8'd3, 8'd32, 1'b0));
    pending_items.push_back(key_beat(8'd4, 8'd126, 1'b0));
    pending_items.push_back(key_beat(8'd5, 8'd127, 1'b0));
    repeat (5) pending_items.push_back(tick_beat());
    pending_items.push_back(key_beat(8'd6, 8'd31, 1'b0));
    pending_items.push_back(key_beat(8'd7, 8'd255, 1'b0));
    repeat (3) pending_items.push_back(tick_beat());
    pending_items.push_back(key_beat(8'd6, 8'd20, 1'b0));
    repeat (5) pending_items.push_back(tick_beat());
    wait_quiet();

    write_timeout(8'd0);
    queue_random(20);
    wait_quiet();

    write_timeout(8'($urandom_range(1, 10)));
    queue_random(25);
    wait_quiet();

    // long timeout: the key stays held through a few ticks
    write_timeout(8'd254);
    @(negedge clk);
    pending_items.push_back(key_beat(8'd9, 8'd120, 1'b0));
    repeat (3) pending_items.push_back(tick_beat());
    wait_quiet();

    write_timeout(kht_pkg::TMO_RESET);
    queue_random(20);
    wait_quiet();

    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", expected_events.size()));
    $display("covered %0d input beats, %0d presses and %0d releases checked",
             items_accepted, presses_seen, releases_seen);
    $display("timeouts 4, 0, random, 254 and 4 again; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kht_pkg.sv
rtl/key_hold_timeout_tracker.sv
bench/key_hold_timeout_tracker_test.sv
